FILE: rtl/sva_pkg.sv
package sva_pkg;

    localparam int MODE_W    = 2;
    localparam int SAMPLE_W  = 10;
    localparam int REF_W     = 21;
    localparam int SUM_W     = 21;
    localparam int VOLT_W    = 16;
    localparam int CODE_W    = 8;

    localparam int SAMPLES_DEF = 4;

    localparam logic [REF_W-1:0]  REF_RESET = 21'd1100000;
    localparam logic [VOLT_W-1:0] VOLT_MAX  = 16'hFFFF;
    localparam logic [CODE_W-1:0] CODE_MAX  = 8'hFF;

    localparam logic [MODE_W-1:0] MODE_REQ   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONV  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ABORT = 2'd2;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_READING = 1'b1;

    typedef struct packed {
        logic load_div;
        logic div_sel_sum;
        logic div_step;
        logic acc;
        logic acc_final;
        logic clear_sum;
        logic emit;
        logic emit_kind;
        logic emit_last;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/sva_dp.sv
module sva_dp
    import sva_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [REF_W-1:0]    i_cfg_data,
    input  logic [SAMPLE_W-1:0] i_adc_sample,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic                o_kind,
    output logic [CODE_W-1:0]   o_voltage_code,
    output logic                o_last
);

    localparam int     AVG_DIV   = SAMPLES * 100;
    localparam int     AVG_SH    = SUM_W + $clog2(AVG_DIV);
    localparam longint AVG_RCP_L = ((longint'(1) << AVG_SH) + longint'(AVG_DIV) - 1)
                                   / longint'(AVG_DIV);
    localparam int     RCP_W     = $clog2(AVG_RCP_L + 1);
    localparam int     PROD_W    = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] AVG_RCP = RCP_W'(AVG_RCP_L);
    localparam int     DIVR_W    = SAMPLE_W;
    localparam int     STEP_W    = $clog2(REF_W);

    logic [REF_W-1:0]  r_ref;
    logic [SUM_W-1:0]  r_sum;
    logic [REF_W-1:0]  r_quo;
    logic [DIVR_W-1:0] r_rem;
    logic [DIVR_W-1:0] r_divisor;
    logic [STEP_W-1:0] r_step;

    logic              r_out_valid;
    logic              r_kind;
    logic [CODE_W-1:0] r_code;
    logic              r_last;

    logic [DIVR_W:0]   w_shift;
    logic [DIVR_W:0]   w_diff;
    logic              w_qbit;
    logic [VOLT_W-1:0] w_volt;
    logic [SUM_W-1:0]  w_sum_next;
    logic [PROD_W-1:0] w_prod;
    logic [CODE_W-1:0] w_avg;
    logic              w_out_free;

    // restoring division, one quotient bit a cycle; a zero divisor yields all ones
    assign w_shift = {r_rem, r_quo[REF_W-1]};
    assign w_diff  = w_shift - {1'b0, r_divisor};
    assign w_qbit  = (w_shift >= {1'b0, r_divisor});

    assign w_volt     = (|r_quo[REF_W-1:VOLT_W]) ? VOLT_MAX : r_quo[VOLT_W-1:0];
    assign w_sum_next = r_sum + SUM_W'(w_volt);

    // multiply the held sum by the rounded-up reciprocal; exact for any sum of this width
    assign w_prod = PROD_W'(r_quo) * PROD_W'(AVG_RCP);
    assign w_avg  = (|w_prod[PROD_W-1:AVG_SH+CODE_W]) ? CODE_MAX
                                                      : w_prod[AVG_SH+CODE_W-1:AVG_SH];

    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_sts.div_last = (r_step == STEP_W'(REF_W - 1));
    assign o_sts.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= REF_RESET;
        end else if (i_cfg_valid) begin
            r_ref <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd.clear_sum) begin
            r_sum <= '0;
        end else if (i_cmd.acc) begin
            // the finished sum moves to the quotient register, so drop it here
            r_sum <= i_cmd.acc_final ? '0 : w_sum_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_div) begin
            r_quo     <= i_cmd.div_sel_sum ? REF_W'(w_sum_next) : r_ref;
            r_divisor <= i_adc_sample;
            r_rem     <= '0;
            r_step    <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[REF_W-2:0], w_qbit};
            r_rem  <= w_qbit ? w_diff[DIVR_W-1:0] : w_shift[DIVR_W-1:0];
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind <= i_cmd.emit_kind;
            r_code <= (i_cmd.emit_kind == KIND_READING) ? w_avg : '0;
            r_last <= i_cmd.emit_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_voltage_code = r_code;
    assign o_last         = r_last;

endmodule

FILE: rtl/sva_ctrl.sv
module sva_ctrl
    import sva_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [MODE_W-1:0] i_mode,
    output logic              o_in_stall,
    input  t_sts              i_sts,
    output t_cmd              o_cmd
);

    localparam int CNT_W = $clog2(SAMPLES + 1);

    typedef enum logic [4:0] {
        S_IDLE       = 5'b00001,
        S_DIV        = 5'b00010,
        S_ACC        = 5'b00100,
        S_EMIT_AVG   = 5'b01000,
        S_EMIT_START = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic             r_measuring, n_measuring;
    logic             r_pending, n_pending;
    logic [CNT_W-1:0] r_count, n_count;

    logic             w_accept;
    logic [CNT_W-1:0] w_count_inc;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_count_inc = r_count + CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_measuring = r_measuring;
        n_pending   = r_pending;
        n_count     = r_count;
        o_cmd       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_mode)
                        MODE_REQ: begin
                            if (!r_measuring) begin
                                n_measuring     = 1'b1;
                                n_pending       = 1'b0;
                                n_count         = '0;
                                o_cmd.clear_sum = 1'b1;
                                n_state         = S_EMIT_START;
                            end else begin
                                n_pending = 1'b1;
                            end
                        end
                        MODE_CONV: begin
                            if (r_measuring) begin
                                o_cmd.load_div = 1'b1;
                                n_state        = S_DIV;
                            end
                        end
                        MODE_ABORT: begin
                            n_measuring     = 1'b0;
                            n_pending       = 1'b0;
                            n_count         = '0;
                            o_cmd.clear_sum = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (w_count_inc == CNT_W'(SAMPLES)) begin
                    // hold the completed sum for the average
                    o_cmd.acc_final   = 1'b1;
                    o_cmd.load_div    = 1'b1;
                    o_cmd.div_sel_sum = 1'b1;
                    n_count           = '0;
                    n_state           = S_EMIT_AVG;
                end else begin
                    n_count = w_count_inc;
                    n_state = S_EMIT_START;
                end
            end
            S_EMIT_AVG: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = KIND_READING;
                    o_cmd.emit_last = !r_pending;
                    if (r_pending) begin
                        // start the remembered run straight away
                        n_measuring     = 1'b1;
                        n_pending       = 1'b0;
                        n_count         = '0;
                        o_cmd.clear_sum = 1'b1;
                        n_state         = S_EMIT_START;
                    end else begin
                        n_measuring = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end
            S_EMIT_START: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = KIND_START;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_measuring <= 1'b0;
            r_pending   <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_measuring <= n_measuring;
            r_pending   <= n_pending;
            r_count     <= n_count;
        end
    end

    a_pending_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> r_measuring)
        else $error("request held pending while no run is active");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(SAMPLES))
        else $error("sample count reached the run length");

    a_acc_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> $past(r_state == S_DIV))
        else $error("accumulate without a finished division");

    a_start_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_START && i_sts.out_free) |=> (r_state == S_IDLE))
        else $error("start command did not return the controller to idle");

endmodule

FILE: rtl/supply_voltage_averager.sv
// Supply voltage averager. Each conversion word (mode 1) is turned into a
// voltage by dividing the reference register by the ADC sample in a bit-serial
// divider, one quotient bit a cycle. Each item passes through accept, the divide
// steps, accumulate, and the placing of a start-kind word in the output
// register. The word that completes a run of SAMPLES conversions places the
// reading instead; its average (sum / (SAMPLES * 100)) comes from a reciprocal
// multiply in the cycle that places it, and a pending request then adds a
// second result. Requests, aborts and ignored words are handled at accept,
// plus the placing of any result. A stalled output register holds the block
// in the placing state until it frees. One word is processed at a time; a new
// word is taken while a finished result still waits in the output register.
// The reference register is always ready and may be written whenever no word
// is in progress.
module supply_voltage_averager
    import sva_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [REF_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [SAMPLE_W-1:0] i_adc_sample,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_kind,
    output logic [CODE_W-1:0]   o_voltage_code,
    output logic                o_last
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    sva_ctrl #(
        .SAMPLES(SAMPLES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_mode    (i_mode),
        .o_in_stall(o_in_stall),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    sva_dp #(
        .SAMPLES(SAMPLES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_adc_sample  (i_adc_sample),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_voltage_code(o_voltage_code),
        .o_last        (o_last)
    );

endmodule
